/* rtl/core/tpovf_pkg.sv */
// shared types and constants of the two-point velocity field core
package tpovf_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_POINT_A     = 3'd0;
  localparam logic [2:0] REG_POINT_B     = 3'd1;
  localparam logic [2:0] REG_SWIPE_SPEED = 3'd2;
  localparam logic [2:0] REG_ORTHO_GAIN  = 3'd3;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;

  // operand widths of the shared units
  localparam int DivW  = 64;
  localparam int DenW  = 36;
  localparam int RootW = 33;

  localparam logic [14:0] SPEED_LIMIT_RST = 15'd4096;

  // request into the iterative divider
  typedef struct packed {
    logic                   start;
    logic signed [DivW-1:0] num;
    logic [DenW-1:0]        den;
  } div_req_t;

  // request into the iterative square root
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] rad;
  } sqrt_req_t;

endpackage

/* rtl/core/tpovf_div.sv */
// iterative rounded divider, one quotient bit per cycle
module tpovf_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tpovf_pkg::div_req_t                  req,
  output logic                                 done,
  output logic signed [tpovf_pkg::DivW-1:0]    quo
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [5:0]                        cnt_r, cnt_nxt;
  logic [tpovf_pkg::DivW-1:0]        dvd_r, dvd_nxt;
  logic [tpovf_pkg::DenW-1:0]        rem_r, rem_nxt;
  logic [tpovf_pkg::DenW-1:0]        den_r, den_nxt;
  logic                              neg_r, neg_nxt;
  logic [tpovf_pkg::DivW-1:0]        mag;
  logic [tpovf_pkg::DenW:0]          rem_sh;
  logic                              ge;

  // magnitude plus half divisor for round half away from zero
  assign mag    = req.num[tpovf_pkg::DivW-1] ? (~req.num + 1'b1) : req.num;
  assign rem_sh = {rem_r, dvd_r[tpovf_pkg::DivW-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd63;
      dvd_nxt  = mag + {{(tpovf_pkg::DivW-tpovf_pkg::DenW){1'b0}}, (req.den >> 1)};
      rem_nxt  = '0;
      den_nxt  = req.den;
      neg_nxt  = req.num[tpovf_pkg::DivW-1];
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh[tpovf_pkg::DenW-1:0] - den_r) : rem_sh[tpovf_pkg::DenW-1:0];
      dvd_nxt = {dvd_r[tpovf_pkg::DivW-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // sign back onto the quotient
  assign done = done_r;
  assign quo  = neg_r ? -$signed(dvd_r) : $signed(dvd_r);

endmodule

/* rtl/core/tpovf_sqrt.sv */
// iterative integer square root, two radicand bits per cycle
module tpovf_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tpovf_pkg::sqrt_req_t            req,
  output logic                            done,
  output logic [tpovf_pkg::RootW-1:0]     root
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tpovf_pkg::DivW-1:0]    x_r, x_nxt;
  logic [tpovf_pkg::DivW-1:0]    res_r, res_nxt;
  logic [tpovf_pkg::DivW-1:0]    bit_r, bit_nxt;
  logic [tpovf_pkg::DivW-1:0]    trial;

  assign trial = res_r + bit_r;

  // digit by digit root, leading empty steps leave res at zero
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      x_nxt    = req.rad;
      res_nxt  = '0;
      bit_nxt  = {2'b01, {(tpovf_pkg::DivW-2){1'b0}}};
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt   = x_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[tpovf_pkg::RootW-1:0];

endmodule

/* rtl/core/two_point_oscillating_velocity_field_core.sv */
// Two-point oscillating velocity field: position sample in, velocity out.
// Input channel in_*: one Q4.12 position per transfer; in_stall is high while
// an item is being worked on and during reset. Output channel out_*: one
// velocity, the goal used and a degenerate flag per input. A finished result
// sits in an output register, so the next position is taken while it waits.
// Config channel cfg_*: write of register index and data, always ready out of
// reset; write only while the core is idle.
// With the output free, an item finishes soonest when the line or projection
// is zero and takes longest when the speed limit applies. One shared 36x28
// multiplier, one 64-step divider and one 32-step square root unit are used
// in turn under a micro sequencer; the six divisions (nine under the limit)
// dominate the time an item takes.
// One item at a time: the next position is taken the cycle after the result
// is written. Reset clears the goal to point a and restores register
// defaults. When the receiver stalls, the result holds and a new finished
// result waits until the output register is free.
module two_point_oscillating_velocity_field_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic signed [15:0] out_vel_z,
  output logic               out_goal_is_b,
  output logic               out_degenerate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // micro operations
  localparam logic [3:0] U_PL  = 4'd0;
  localparam logic [3:0] U_LL  = 4'd1;
  localparam logic [3:0] U_PP  = 4'd2;
  localparam logic [3:0] U_PLL = 4'd3;
  localparam logic [3:0] U_LPJ = 4'd4;
  localparam logic [3:0] U_GO  = 4'd5;
  localparam logic [3:0] U_SL  = 4'd6;
  localparam logic [3:0] U_VV  = 4'd7;
  localparam logic [3:0] U_LIM = 4'd8;
  localparam logic [3:0] U_VL  = 4'd9;

  logic [2:0]         state_r, state_nxt;
  logic [3:0]         uop_r, uop_nxt;
  logic [1:0]         i_r, i_nxt;
  logic               lim_phase_r, lim_phase_nxt;
  logic               heading_r, heading_nxt;
  logic               goal_r, goal_nxt;
  logic               degen_r, degen_nxt;

  logic [47:0]        point_a_r, point_a_nxt;
  logic [47:0]        point_b_r, point_b_nxt;
  logic [14:0]        swipe_r, swipe_nxt;
  logic [15:0]        gain_r, gain_nxt;
  logic [14:0]        lim_r, lim_nxt;

  logic signed [16:0] p_r [3];
  logic signed [16:0] p_nxt [3];
  logic signed [16:0] l_r [3];
  logic signed [16:0] l_nxt [3];
  logic signed [26:0] v_r [3];
  logic signed [26:0] v_nxt [3];

  logic signed [63:0] prod_r, prod_nxt;
  logic signed [34:0] proj_r, proj_nxt;
  logic [33:0]        l2_r, l2_nxt;
  logic [33:0]        p2_r, p2_nxt;
  logic signed [52:0] num_r, num_nxt;
  logic [tpovf_pkg::RootW-1:0] rn_r, rn_nxt;
  logic [tpovf_pkg::RootW-1:0] rv_r, rv_nxt;
  logic signed [19:0] orth_r, orth_nxt;
  logic signed [26:0] vo_r, vo_nxt;
  logic [53:0]        v2_r, v2_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_x_r, out_x_nxt;
  logic signed [15:0] out_y_r, out_y_nxt;
  logic signed [15:0] out_z_r, out_z_nxt;
  logic               out_goal_r, out_goal_nxt;
  logic               out_degen_r, out_degen_nxt;

  logic signed [35:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [15:0] sp;
  logic [63:0]        go_mag;
  logic [63:0]        go_q;
  logic [40:0]        p2_x100;
  logic [47:0]        goal_w, other_w;
  logic signed [15:0] pos [3];
  logic               in_xfer;
  logic               out_free;

  tpovf_pkg::div_req_t                 div_req;
  logic                                div_done;
  logic signed [tpovf_pkg::DivW-1:0]   div_q;
  tpovf_pkg::sqrt_req_t                sqrt_req;
  logic                                sqrt_done;
  logic [tpovf_pkg::RootW-1:0]         sqrt_root;

  tpovf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_q)
  );

  tpovf_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sqrt_req),
    .done (sqrt_done),
    .root (sqrt_root)
  );

  // handshakes
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign cfg_ready = rst_n;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign pos[0]  = in_pos_x;
  assign pos[1]  = in_pos_y;
  assign pos[2]  = in_pos_z;
  assign goal_w  = heading_r ? point_b_r : point_a_r;
  assign other_w = heading_r ? point_a_r : point_b_r;

  // swipe speed points against the sign of the projection
  assign sp = (proj_r > 35'sd0) ? -$signed({1'b0, swipe_r}) : $signed({1'b0, swipe_r});

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uop_r)
      U_PL: begin
        mul_a = 36'(p_r[i_r]);
        mul_b = 28'(l_r[i_r]);
      end
      U_LL: begin
        mul_a = 36'(l_r[i_r]);
        mul_b = 28'(l_r[i_r]);
      end
      U_PP: begin
        mul_a = 36'(p_r[i_r]);
        mul_b = 28'(p_r[i_r]);
      end
      U_PLL: begin
        mul_a = $signed({2'b00, l2_r});
        mul_b = 28'(p_r[i_r]);
      end
      U_LPJ: begin
        mul_a = 36'(proj_r);
        mul_b = 28'(l_r[i_r]);
      end
      U_GO: begin
        mul_a = 36'(orth_r);
        mul_b = $signed({12'd0, gain_r});
      end
      U_SL: begin
        mul_a = $signed({{7{l_r[i_r][16]}}, l_r[i_r], 12'd0});
        mul_b = 28'(sp);
      end
      U_VV: begin
        mul_a = 36'(v_r[i_r]);
        mul_b = 28'(v_r[i_r]);
      end
      U_LIM: begin
        mul_a = $signed({21'd0, lim_r});
        mul_b = $signed({13'd0, lim_r});
      end
      U_VL: begin
        mul_a = 36'(v_r[i_r]);
        mul_b = $signed({7'd0, lim_r, 6'd0});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // orthogonal damping term, rounded divide by 256 and negated
  assign go_mag = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
  assign go_q   = (go_mag + 64'd128) >> 8;

  // toggle test 100 * |p|^2 < |l|^2
  assign p2_x100 = {1'b0, p2_r, 6'd0} + {2'b00, p2_r, 5'd0} + {5'd0, p2_r, 2'd0};

  // unit requests
  always_comb begin
    div_req       = '0;
    sqrt_req      = '0;
    div_req.start = (state_r == S_ACC) &&
                    ((uop_r == U_LPJ) || (uop_r == U_SL) || (uop_r == U_VL));
    case (uop_r)
      U_LPJ: begin
        div_req.num = 64'(num_r) - prod_r;
        div_req.den = {2'b00, l2_r};
      end
      U_SL: begin
        div_req.num = prod_r;
        div_req.den = {3'd0, rn_r};
      end
      default: begin
        div_req.num = prod_r;
        div_req.den = {3'd0, rv_r};
      end
    endcase
    if ((state_r == S_ACC) && (uop_r == U_PP) && (i_r == 2'd2) &&
        (l2_r != '0) && (proj_r != '0)) begin
      sqrt_req.start = 1'b1;
      sqrt_req.rad   = {6'd0, l2_r, 24'd0};
    end else if ((state_r == S_ACC) && (uop_r == U_LIM) &&
                 (v2_r > {24'd0, prod_r[29:0]})) begin
      sqrt_req.start = 1'b1;
      sqrt_req.rad   = {v2_r[51:0], 12'd0};
    end
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    uop_nxt       = uop_r;
    i_nxt         = i_r;
    lim_phase_nxt = lim_phase_r;
    heading_nxt   = heading_r;
    goal_nxt      = goal_r;
    degen_nxt     = degen_r;
    point_a_nxt   = point_a_r;
    point_b_nxt   = point_b_r;
    swipe_nxt     = swipe_r;
    gain_nxt      = gain_r;
    lim_nxt       = lim_r;
    prod_nxt      = prod_r;
    proj_nxt      = proj_r;
    l2_nxt        = l2_r;
    p2_nxt        = p2_r;
    num_nxt       = num_r;
    rn_nxt        = rn_r;
    rv_nxt        = rv_r;
    orth_nxt      = orth_r;
    vo_nxt        = vo_r;
    v2_nxt        = v2_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_goal_nxt  = out_goal_r;
    out_degen_nxt = out_degen_r;
    for (int k = 0; k < 3; k++) begin
      p_nxt[k] = p_r[k];
      l_nxt[k] = l_r[k];
      v_nxt[k] = v_r[k];
    end

    // configuration writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpovf_pkg::REG_POINT_A:     point_a_nxt = cfg_data;
        tpovf_pkg::REG_POINT_B:     point_b_nxt = cfg_data;
        tpovf_pkg::REG_SWIPE_SPEED: swipe_nxt   = cfg_data[14:0];
        tpovf_pkg::REG_ORTHO_GAIN:  gain_nxt    = cfg_data[15:0];
        tpovf_pkg::REG_SPEED_LIMIT: lim_nxt     = cfg_data[14:0];
        default: ;
      endcase
    end

    // output transfer frees the register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          for (int k = 0; k < 3; k++) begin
            p_nxt[k] = 17'(pos[k]) - 17'($signed(goal_w[16*k +: 16]));
            l_nxt[k] = 17'($signed(other_w[16*k +: 16])) -
                       17'($signed(goal_w[16*k +: 16]));
            v_nxt[k] = '0;
          end
          proj_nxt  = '0;
          l2_nxt    = '0;
          p2_nxt    = '0;
          v2_nxt    = '0;
          degen_nxt = 1'b0;
          goal_nxt  = heading_r;
          i_nxt     = 2'd0;
          uop_nxt   = U_PL;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = S_MUL;
        case (uop_r)
          U_PL: begin
            proj_nxt = proj_r + prod_r[34:0];
            uop_nxt  = U_LL;
          end
          U_LL: begin
            l2_nxt  = l2_r + prod_r[33:0];
            uop_nxt = U_PP;
          end
          U_PP: begin
            p2_nxt = p2_r + prod_r[33:0];
            if (i_r != 2'd2) begin
              i_nxt   = i_r + 2'd1;
              uop_nxt = U_PL;
            end else if ((l2_r == '0) || (proj_r == '0)) begin
              degen_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              lim_phase_nxt = 1'b0;
              state_nxt     = S_SQRT;
            end
          end
          U_PLL: begin
            num_nxt = prod_r[52:0];
            uop_nxt = U_LPJ;
          end
          U_GO: begin
            vo_nxt  = prod_r[63] ? 27'(go_q) : 27'(-go_q);
            uop_nxt = U_SL;
          end
          U_VV: begin
            v2_nxt = v2_r + prod_r[53:0];
            if (i_r != 2'd2) begin
              i_nxt   = i_r + 2'd1;
              uop_nxt = U_PLL;
            end else begin
              uop_nxt = U_LIM;
            end
          end
          U_LIM: begin
            if (v2_r > {24'd0, prod_r[29:0]}) begin
              lim_phase_nxt = 1'b1;
              state_nxt     = S_SQRT;
            end else begin
              state_nxt = S_OUT;
            end
          end
          default: begin
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
          case (uop_r)
            U_LPJ: begin
              orth_nxt = div_q[19:0];
              uop_nxt  = U_GO;
            end
            U_SL: begin
              v_nxt[i_r] = div_q[26:0] + vo_r;
              uop_nxt    = U_VV;
            end
            default: begin
              v_nxt[i_r] = div_q[26:0];
              if (i_r != 2'd2) begin
                i_nxt = i_r + 2'd1;
              end else begin
                state_nxt = S_OUT;
              end
            end
          endcase
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          i_nxt     = 2'd0;
          state_nxt = S_MUL;
          if (lim_phase_r) begin
            rv_nxt  = sqrt_root;
            uop_nxt = U_VL;
          end else begin
            rn_nxt  = sqrt_root;
            uop_nxt = U_PLL;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = v_r[0][15:0];
          out_y_nxt     = v_r[1][15:0];
          out_z_nxt     = v_r[2][15:0];
          out_goal_nxt  = goal_r;
          out_degen_nxt = degen_r;
          if (p2_x100 < {7'd0, l2_r}) begin
            heading_nxt = !heading_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heading_r   <= 1'b0;
      out_valid_r <= 1'b0;
      point_a_r   <= '0;
      point_b_r   <= '0;
      swipe_r     <= '0;
      gain_r      <= '0;
      lim_r       <= tpovf_pkg::SPEED_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      heading_r   <= heading_nxt;
      out_valid_r <= out_valid_nxt;
      point_a_r   <= point_a_nxt;
      point_b_r   <= point_b_nxt;
      swipe_r     <= swipe_nxt;
      gain_r      <= gain_nxt;
      lim_r       <= lim_nxt;
    end
    uop_r       <= uop_nxt;
    i_r         <= i_nxt;
    lim_phase_r <= lim_phase_nxt;
    goal_r      <= goal_nxt;
    degen_r     <= degen_nxt;
    prod_r      <= prod_nxt;
    proj_r      <= proj_nxt;
    l2_r        <= l2_nxt;
    p2_r        <= p2_nxt;
    num_r       <= num_nxt;
    rn_r        <= rn_nxt;
    rv_r        <= rv_nxt;
    orth_r      <= orth_nxt;
    vo_r        <= vo_nxt;
    v2_r        <= v2_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_z_r     <= out_z_nxt;
    out_goal_r  <= out_goal_nxt;
    out_degen_r <= out_degen_nxt;
    for (int k = 0; k < 3; k++) begin
      p_r[k] <= p_nxt[k];
      l_r[k] <= l_nxt[k];
      v_r[k] <= v_nxt[k];
    end
  end

  // output ports
  assign out_valid      = out_valid_r;
  assign out_vel_x      = out_x_r;
  assign out_vel_y      = out_y_r;
  assign out_vel_z      = out_z_r;
  assign out_goal_is_b  = out_goal_r;
  assign out_degenerate = out_degen_r;

endmodule

/* rtl/core/tpovf_chk.sv */
// port checker for the two-point velocity field core, with its bind
module tpovf_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_vel_x,
  input logic signed [15:0] out_vel_y,
  input logic signed [15:0] out_vel_z,
  input logic               out_degenerate
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a degenerate result carries zero velocity
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> (out_vel_x == 16'sd0) && (out_vel_y == 16'sd0) &&
                                    (out_vel_z == 16'sd0))
    else $error("degenerate result with nonzero velocity");

  // one item at a time: an input transfer closes the input side
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while item in work");

  // a new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");

endmodule

bind two_point_oscillating_velocity_field_core tpovf_chk u_tpovf_chk (.*);
